FILE: rtl/rip_packet_parse_validate_unit_defines.svh
// Assertion macros shared by the RIPv2 parse/validate checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef RIP_PACKET_PARSE_VALIDATE_UNIT_DEFINES_SVH
`define RIP_PACKET_PARSE_VALIDATE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rpv_pkg.sv
// Package for the RIPv2 packet parse/validate unit: payload types, header
// offsets, entry layout and protocol codes. No dependencies.
package rpv_pkg;

   // Route entries accepted per packet (1..31).
   localparam int MAX_ENTRIES = 25;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_req;
      logic [15:0] buffer_len;
   } req_payload_type;

   typedef struct packed {
      logic        is_entry;
      logic [4:0]  entry_index;
      logic [1:0]  command;
      logic [31:0] route_addr;
      logic [31:0] route_mask;
      logic [31:0] route_nexthop;
      logic [31:0] route_metric;
      logic        packet_ok;
      logic        last;
   } rsp_payload_type;

   // One processed byte: whether it yields a transaction, and its contents.
   typedef struct packed {
      logic            emit;
      rsp_payload_type rsp;
   } step_result_type;

   typedef logic [1:0] cmd_type;
   typedef logic [5:0] pos_type;
   typedef logic [4:0] slot_type;

   localparam cmd_type CMD_NONE     = 2'd0;
   localparam cmd_type CMD_REQUEST  = 2'd1;
   localparam cmd_type CMD_RESPONSE = 2'd2;

   localparam logic [7:0]  RIP_VERSION  = 8'd2;
   localparam logic [15:0] FAMILY_NONE  = 16'd0;
   localparam logic [15:0] FAMILY_INET  = 16'd2;
   localparam logic [7:0]  METRIC_MIN   = 8'd1;
   localparam logic [7:0]  METRIC_MAX   = 8'd16;

   // Header byte offsets (fixed 20-byte IP header + 8-byte UDP header).
   localparam pos_type POS_TLEN_HI = 6'd2;
   localparam pos_type POS_TLEN_LO = 6'd3;
   localparam pos_type POS_CMD     = 6'd28;
   localparam pos_type POS_VER     = 6'd29;
   localparam pos_type POS_ZERO_HI = 6'd30;
   localparam pos_type POS_ZERO_LO = 6'd31;
   localparam pos_type HDR_BYTES   = 6'd32;

   // Byte slots within a 20-byte route entry.
   localparam slot_type K_FAM_LAST     = 5'd3;
   localparam slot_type K_ADDR_FIRST   = 5'd4;
   localparam slot_type K_MASK_FIRST   = 5'd8;
   localparam slot_type K_MASK_LAST    = 5'd11;
   localparam slot_type K_NHOP_FIRST   = 5'd12;
   localparam slot_type K_METRIC_FIRST = 5'd16;
   localparam slot_type K_METRIC_LAST  = 5'd19;

   localparam int ENTRY_BYTES = 20;

   localparam logic [15:0] MIN_TOTAL      = 16'd32;
   localparam logic [15:0] NO_ENTRY_TOTAL = 16'(32 + ENTRY_BYTES);
   localparam logic [15:0] TOTAL_OVER     = 16'(32 + ENTRY_BYTES * (MAX_ENTRIES + 1));
   localparam logic [15:0] LAST_BASE      = 16'(32 + 2 * ENTRY_BYTES);
   localparam logic [15:0] ENTRY_STRIDE   = 16'(ENTRY_BYTES);

endpackage

FILE: rtl/rpv_parse_core.sv
// Parse state and per-byte check logic of the RIPv2 parse/validate unit.
// Depends on rpv_pkg.
module rpv_parse_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  rpv_pkg::req_payload_type req,
   output rpv_pkg::step_result_type result
);
   import rpv_pkg::*;

   logic        active_ff, active_in;
   pos_type     pos_ff, pos_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] total_ff, total_in;
   cmd_type     cmd_ff, cmd_in;
   slot_type    k_ff, k_in;
   logic [4:0]  idx_ff, idx_in;
   logic [23:0] ftw_ff, ftw_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] nhop_ff, nhop_in;
   logic [23:0] metric_ff, metric_in;

   logic        cur_active;
   pos_type     cur_pos;
   logic [15:0] cur_total;
   cmd_type     cur_cmd;
   slot_type    cur_k;
   logic [4:0]  cur_idx;
   logic [7:0]  b;
   logic [1:0]  lane;
   logic [15:0] tlen;
   logic [15:0] fam;
   logic [15:0] tag;
   logic [31:0] m;
   logic [15:0] last_bound;
   logic        fail;
   logic        fin_ok;
   logic        entry_out;
   logic        entry_last;

   function automatic logic [31:0] put_byte(logic [31:0] w, logic [1:0] ln, logic [7:0] v);
      logic [31:0] r;
      r = w;
      case (ln)
         2'd0:    r[7:0]   = v;
         2'd1:    r[15:8]  = v;
         2'd2:    r[23:16] = v;
         default: r[31:24] = v;
      endcase
      return r;
   endfunction

   always_comb begin
      b          = req.data_byte;
      cur_active = active_ff;
      cur_pos    = pos_ff;
      cur_total  = total_ff;
      cur_cmd    = cmd_ff;
      cur_k      = k_ff;
      cur_idx    = idx_ff;
      limit_in   = limit_ff;
      if (req.start_req) begin
         // restart: drop any packet in flight
         cur_active = 1'b1;
         cur_pos    = '0;
         cur_total  = '0;
         cur_cmd    = CMD_NONE;
         cur_k      = '0;
         cur_idx    = '0;
         limit_in   = req.buffer_len;
      end

      active_in = cur_active;
      pos_in    = cur_pos;
      total_in  = cur_total;
      cmd_in    = cur_cmd;
      k_in      = cur_k;
      idx_in    = cur_idx;
      ftw_in    = ftw_ff;
      addr_in   = addr_ff;
      mask_in   = mask_ff;
      nhop_in   = nhop_ff;
      metric_in = metric_ff;

      lane       = cur_k[1:0];
      tlen       = {cur_total[15:8], b};
      fam        = {ftw_ff[7:0], ftw_ff[15:8]};
      tag        = {b, ftw_ff[23:16]};
      m          = {mask_ff[7:0], mask_ff[15:8], mask_ff[23:16], b};
      last_bound = LAST_BASE + 16'(cur_idx) * ENTRY_STRIDE;
      fail       = 1'b0;
      fin_ok     = 1'b0;
      entry_out  = 1'b0;
      entry_last = 1'b0;

      if (cur_active) begin
         if (cur_pos != HDR_BYTES) begin
            pos_in = cur_pos + 6'd1;
            unique case (cur_pos)
               POS_TLEN_HI: total_in = {b, 8'h00};
               POS_TLEN_LO: begin
                  total_in = tlen;
                  if (tlen > limit_in || tlen < MIN_TOTAL || tlen >= TOTAL_OVER) begin
                     fail = 1'b1;
                  end
               end
               POS_CMD: begin
                  if (b == 8'(CMD_REQUEST)) begin
                     cmd_in = CMD_REQUEST;
                  end else if (b == 8'(CMD_RESPONSE)) begin
                     cmd_in = CMD_RESPONSE;
                  end else begin
                     cmd_in = CMD_NONE;
                     fail   = 1'b1;
                  end
               end
               POS_VER:     fail = (b != RIP_VERSION);
               POS_ZERO_HI: fail = (b != 8'h00);
               POS_ZERO_LO: begin
                  if (b != 8'h00) begin
                     fail = 1'b1;
                  end else if (cur_total < NO_ENTRY_TOTAL) begin
                     fin_ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end else begin
            // route entry bytes; every lane of a word lands before it is used
            if (cur_k < K_ADDR_FIRST) begin
               ftw_in = 24'(put_byte({8'h00, ftw_ff}, lane, b));
            end else if (cur_k < K_MASK_FIRST) begin
               addr_in = put_byte(addr_ff, lane, b);
            end else if (cur_k < K_NHOP_FIRST) begin
               mask_in = put_byte(mask_ff, lane, b);
            end else if (cur_k < K_METRIC_FIRST) begin
               nhop_in = put_byte(nhop_ff, lane, b);
            end else begin
               metric_in = 24'(put_byte({8'h00, metric_ff}, lane, b));
            end

            if (cur_k == K_FAM_LAST) begin
               fail = (cur_cmd == CMD_REQUEST && fam != FAMILY_NONE) ||
                      (cur_cmd == CMD_RESPONSE && fam != FAMILY_INET) ||
                      (tag != 16'h0000);
            end else if (cur_k == K_MASK_LAST) begin
               fail = (((m - 32'd1) | m) != 32'hffff_ffff);
            end else if (cur_k == K_METRIC_LAST) begin
               if (metric_ff != 24'h0 || b < METRIC_MIN || b > METRIC_MAX) begin
                  fail = 1'b1;
               end else begin
                  entry_out  = 1'b1;
                  entry_last = (cur_total < last_bound);
               end
            end

            if (cur_k == K_METRIC_LAST) begin
               k_in   = '0;
               idx_in = cur_idx + 5'd1;
            end else begin
               k_in = cur_k + 5'd1;
            end
         end
      end

      if (fail || fin_ok || entry_last) begin
         active_in = 1'b0;
      end

      result                   = '0;
      result.emit              = fail || fin_ok || entry_out;
      result.rsp.is_entry      = entry_out;
      result.rsp.entry_index   = cur_idx;
      result.rsp.command       = cmd_in;
      result.rsp.route_addr    = entry_out ? addr_ff : 32'h0;
      result.rsp.route_mask    = entry_out ? mask_ff : 32'h0;
      result.rsp.route_nexthop = entry_out ? nhop_ff : 32'h0;
      result.rsp.route_metric  = entry_out ? {b, metric_ff} : 32'h0;
      result.rsp.packet_ok     = fin_ok || entry_last;
      result.rsp.last          = fail || fin_ok || entry_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         limit_ff  <= '0;
         total_ff  <= '0;
         cmd_ff    <= CMD_NONE;
         k_ff      <= '0;
         idx_ff    <= '0;
      end else if (step) begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         limit_ff  <= limit_in;
         total_ff  <= total_in;
         cmd_ff    <= cmd_in;
         k_ff      <= k_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ftw_ff    <= ftw_in;
         addr_ff   <= addr_in;
         mask_ff   <= mask_in;
         nhop_ff   <= nhop_in;
         metric_ff <= metric_in;
      end
   end

endmodule

FILE: rtl/rpv_rsp_stage.sv
// Result register of the RIPv2 parse/validate unit with valid/ready output.
// Depends on rpv_pkg.
module rpv_rsp_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  rpv_pkg::rsp_payload_type load_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rpv_pkg::rsp_payload_type rsp_payload
);
   import rpv_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff;

   // load is only raised when the register is empty or draining
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= load_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

FILE: rtl/rip_packet_parse_validate_unit.sv
// RIPv2 packet parse/validate unit: top level with the input register.
// Depends on rpv_pkg, rpv_parse_core and rpv_rsp_stage.
//
// Usage:
//   req_* carries one packet byte per transaction in wire order; start_req
//   marks byte 0 and samples buffer_len. A start in mid-packet abandons the
//   old packet silently.
//   rsp_* returns zero or one transaction per input byte: a route entry when
//   its 20th byte passes its checks, or a verdict (last=1) on the first error,
//   on an empty packet at byte 31, or with the final entry.
// Path: a byte accepted into the input register is processed from there, and its
//   result, if any, is registered in the result register that the receiver sees.
// Throughput: one byte per cycle; the input register and the result register
//   each take a new transaction whenever their downstream side moves.
// Reset: synchronous; clears both valid flags and puts the parser idle, so
//   bytes without start_req are dropped until the first start.
// Stall: while rsp_ready is low with a result held, the parse stage holds its
//   byte; req_ready drops once the input register is also full.
module rip_packet_parse_validate_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rpv_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rpv_pkg::rsp_payload_type rsp_payload
);
   import rpv_pkg::*;

   logic            req_valid_ff, req_valid_in;
   req_payload_type req_ff;
   logic            step;
   step_result_type result;

   // the held byte moves on once the result register can take its result
   assign step      = req_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !req_valid_ff || step;

   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   rpv_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req_ff),
      .result (result)
   );

   rpv_rsp_stage u_rsp (
      .clock        (clock),
      .reset        (reset),
      .load         (step && result.emit),
      .load_payload (result.rsp),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

FILE: rtl/rpv_checker.sv
// Port-level checker for the RIPv2 parse/validate unit, bound to the top.
// Depends on rpv_pkg and rip_packet_parse_validate_unit_defines.svh.
`include "rip_packet_parse_validate_unit_defines.svh"

module rpv_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rpv_pkg::rsp_payload_type rsp_payload
);
   import rpv_pkg::*;

   logic rsp_stall;
   logic rsp_verdict;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_verdict = rsp_valid && !rsp_payload.is_entry;

   `RPV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_payload), "stalled transaction changed")

   `RPV_ASSERT_SAME(a_ok_needs_last, clock, reset, rsp_valid && rsp_payload.packet_ok,
      rsp_payload.last, "packet_ok without last")

   `RPV_ASSERT_SAME(a_verdict_no_words, clock, reset, rsp_verdict,
      rsp_payload.route_addr == 32'h0 && rsp_payload.route_mask == 32'h0 &&
      rsp_payload.route_nexthop == 32'h0 && rsp_payload.route_metric == 32'h0,
      "verdict carries route words")

   `RPV_ASSERT_SAME(a_entry_command, clock, reset, rsp_valid && rsp_payload.is_entry,
      rsp_payload.command == CMD_REQUEST || rsp_payload.command == CMD_RESPONSE,
      "route entry without a valid command")

   `RPV_ASSERT_SAME(a_last_entry_ok, clock, reset,
      rsp_valid && rsp_payload.is_entry && rsp_payload.last,
      rsp_payload.packet_ok, "final entry not accepted")

endmodule

bind rip_packet_parse_validate_unit rpv_checker u_rpv_checker (.*);
